>>> sv/tqvg_pkg.sv
`default_nettype none

package tqvg_pkg;

    // field widths
    localparam int CELL_W  = 16;
    localparam int TILE_W  = 16;
    localparam int MAPW_W  = 11;
    localparam int TW_W    = 9;
    localparam int TEXW_W  = 15;
    localparam int X_W     = 19;
    localparam int Y_W     = 25;
    localparam int U_W     = 15;
    localparam int V_W     = 25;
    localparam int VTX_W   = 3;

    // divider geometry: one shared datapath width, two quotient bits per stage
    localparam int DIV_W          = 16;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = DIV_W / BITS_PER_STAGE;
    localparam int COLS_CNT_W     = 4;

    // cells at or beyond this index are outside the map store
    localparam logic [CELL_W:0] MAX_CELLS = 17'd65536;

    // configuration register indexes
    localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
    localparam logic [1:0] REG_TILE_WIDTH    = 2'd1;
    localparam logic [1:0] REG_TILE_HEIGHT   = 2'd2;
    localparam logic [1:0] REG_TEXTURE_WIDTH = 2'd3;

    // reset values of the configuration registers
    localparam logic [MAPW_W-1:0] MAP_WIDTH_RST     = 11'd1;
    localparam logic [TW_W-1:0]   TILE_WIDTH_RST    = 9'd16;
    localparam logic [TW_W-1:0]   TILE_HEIGHT_RST   = 9'd16;
    localparam logic [TEXW_W-1:0] TEXTURE_WIDTH_RST = 15'd256;
    localparam logic [TEXW_W-1:0] COLS_RST          = 15'd16;

    // quad vertex order: two triangles
    typedef enum logic [VTX_W-1:0] {
        VTX_BL_A = 3'd0,
        VTX_TR_A = 3'd1,
        VTX_TL   = 3'd2,
        VTX_BL_B = 3'd3,
        VTX_BR   = 3'd4,
        VTX_TR_B = 3'd5
    } vertex_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(
        input logic [DIV_W-1:0] rem,
        input logic             dbit,
        input logic [DIV_W-1:0] dsr
    );
        logic [DIV_W:0] t;
        logic [DIV_W:0] r;
        t = {rem, dbit};
        if (t >= {1'b0, dsr}) begin
            r = {1'b1, DIV_W'(t - {1'b0, dsr})};
        end else begin
            r = {1'b0, t[DIV_W-1:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/tilemap_quad_vertex_generator_top.sv
`default_nettype none

// Tile map to quad vertex generator.
// Input words (s_cell_index, s_tile_number) describe one map cell each. An empty
// cell (tile 0) is consumed and produces nothing; any other tile produces six
// output words, the vertices of two triangles, vertex_number 0..5 with
// last_vertex set on vertex 5.
// Datapath: eight stages of a pipelined restoring divider (two quotient bits a
// stage, cell / map_width and (tile - 1) / tileset columns side by side), one
// multiply stage, and an output register that adds the tile extent on load
// and steps through the six vertices.
// The single output channel sets the pace: the whole pipeline holds while the
// output register holds a quad whose last vertex has not been taken, and
// otherwise empty cells pass at one per cycle.
// The tileset column count is found by an iterative divider after every
// configuration write; s_ready stays low after the last write until it is done.
// Reset clears all valid bits, loads the register defaults and the column
// count that matches them, so the block is ready the cycle after reset.
module tilemap_quad_vertex_generator_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_addr,
    input  wire logic [tqvg_pkg::TEXW_W-1:0]  cfg_wdata,
    // cell input
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [tqvg_pkg::CELL_W-1:0]  s_cell_index,
    input  wire logic [tqvg_pkg::TILE_W-1:0]  s_tile_number,
    // vertex output
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic [tqvg_pkg::X_W-1:0]     m_pos_x,
    output      logic [tqvg_pkg::Y_W-1:0]     m_pos_y,
    output      logic [tqvg_pkg::U_W-1:0]     m_tex_u,
    output      logic [tqvg_pkg::V_W-1:0]     m_tex_v,
    output      logic [tqvg_pkg::VTX_W-1:0]   m_vertex_number,
    output      logic                         m_last_vertex
);

    localparam int DW   = tqvg_pkg::DIV_W;
    localparam int NST  = tqvg_pkg::DIV_STAGES;

    // configuration registers
    logic [tqvg_pkg::MAPW_W-1:0] map_width_reg;
    logic [tqvg_pkg::TW_W-1:0]   tile_width_reg;
    logic [tqvg_pkg::TW_W-1:0]   tile_height_reg;
    logic [tqvg_pkg::TEXW_W-1:0] texture_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg     <= tqvg_pkg::MAP_WIDTH_RST;
            tile_width_reg    <= tqvg_pkg::TILE_WIDTH_RST;
            tile_height_reg   <= tqvg_pkg::TILE_HEIGHT_RST;
            texture_width_reg <= tqvg_pkg::TEXTURE_WIDTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tqvg_pkg::REG_MAP_WIDTH: begin
                    map_width_reg <= cfg_wdata[tqvg_pkg::MAPW_W-1:0];
                end
                tqvg_pkg::REG_TILE_WIDTH: begin
                    tile_width_reg <= cfg_wdata[tqvg_pkg::TW_W-1:0];
                end
                tqvg_pkg::REG_TILE_HEIGHT: begin
                    tile_height_reg <= cfg_wdata[tqvg_pkg::TW_W-1:0];
                end
                tqvg_pkg::REG_TEXTURE_WIDTH: begin
                    texture_width_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // tileset column count: texture_width / tile_width, one bit per cycle
    logic                             cols_busy_reg;
    logic [tqvg_pkg::COLS_CNT_W-1:0]  cols_cnt_reg;
    logic [DW-1:0]                    cols_rem_reg;
    logic [tqvg_pkg::TEXW_W-1:0]      cols_q_reg;
    logic [tqvg_pkg::TEXW_W-1:0]      cols_reg;
    logic [tqvg_pkg::COLS_CNT_W-1:0]  cols_bit_idx;
    logic [DW:0]                      cols_step;
    logic [tqvg_pkg::TEXW_W-1:0]      cols_q_next;
    logic                             cols_last;

    assign cols_bit_idx = tqvg_pkg::COLS_CNT_W'(tqvg_pkg::TEXW_W - 1) - cols_cnt_reg;
    assign cols_step    = tqvg_pkg::div_step(cols_rem_reg, texture_width_reg[cols_bit_idx],
                                             DW'(tile_width_reg));
    assign cols_q_next  = {cols_q_reg[tqvg_pkg::TEXW_W-2:0], cols_step[DW]};
    assign cols_last    = (cols_cnt_reg == tqvg_pkg::COLS_CNT_W'(tqvg_pkg::TEXW_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_busy_reg <= 1'b0;
            cols_cnt_reg  <= '0;
            cols_rem_reg  <= '0;
            cols_q_reg    <= '0;
            cols_reg      <= tqvg_pkg::COLS_RST;
        end else if (cfg_wr_en) begin
            cols_busy_reg <= 1'b1;
            cols_cnt_reg  <= '0;
            cols_rem_reg  <= '0;
            cols_q_reg    <= '0;
        end else if (cols_busy_reg) begin
            cols_rem_reg <= cols_step[DW-1:0];
            cols_q_reg   <= cols_q_next;
            cols_cnt_reg <= cols_cnt_reg + 1'b1;
            if (cols_last) begin
                cols_busy_reg <= 1'b0;
                cols_reg      <= (tile_width_reg == '0) ? '0 : cols_q_next;
            end
        end
    end

    // divisors for the cell pipeline
    logic [DW-1:0] mw_div;
    logic [DW-1:0] cols_div;
    logic          cols_zero;

    assign mw_div    = (map_width_reg == '0) ? DW'(1) : DW'(map_width_reg);
    assign cols_div  = DW'(cols_reg);
    assign cols_zero = (cols_reg == '0);

    // pipeline advance: the output register is free or hands over its last vertex
    logic                         ser_valid_reg;
    logic [tqvg_pkg::VTX_W-1:0]   vtx_cnt_reg;
    logic                         adv;

    assign adv     = !ser_valid_reg || (m_ready && vtx_cnt_reg == tqvg_pkg::VTX_TR_B);
    assign s_ready = adv && !cols_busy_reg;

    // empty cells and cells outside the map store are dropped at entry
    logic in_live;
    assign in_live = s_valid && s_ready && (s_tile_number != '0)
                     && ({1'b0, s_cell_index} < tqvg_pkg::MAX_CELLS);

    // divider stages: a = cell / map_width, b = (tile - 1) / columns
    logic [NST-1:0] dv_valid_reg;
    logic [DW-1:0]  dq_a_reg  [NST];
    logic [DW-1:0]  rem_a_reg [NST];
    logic [DW-1:0]  dq_b_reg  [NST];
    logic [DW-1:0]  rem_b_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_div
        logic          v_in;
        logic [DW-1:0] a_dq_in, a_rem_in, b_dq_in, b_rem_in;
        logic [DW-1:0] a_dq, a_rem, b_dq, b_rem;
        logic [DW:0]   sa, sb;

        if (k == 0) begin : g_src_in
            assign v_in     = in_live;
            assign a_dq_in  = s_cell_index;
            assign a_rem_in = '0;
            assign b_dq_in  = s_tile_number - 1'b1;
            assign b_rem_in = '0;
        end else begin : g_src_prev
            assign v_in     = dv_valid_reg[k-1];
            assign a_dq_in  = dq_a_reg[k-1];
            assign a_rem_in = rem_a_reg[k-1];
            assign b_dq_in  = dq_b_reg[k-1];
            assign b_rem_in = rem_b_reg[k-1];
        end

        // quotient bits shift in at the bottom as dividend bits leave the top
        always_comb begin
            a_dq  = a_dq_in;
            a_rem = a_rem_in;
            b_dq  = b_dq_in;
            b_rem = b_rem_in;
            sa    = '0;
            sb    = '0;
            for (int i = 0; i < tqvg_pkg::BITS_PER_STAGE; i++) begin
                sa    = tqvg_pkg::div_step(a_rem, a_dq[DW-1], mw_div);
                a_dq  = {a_dq[DW-2:0], sa[DW]};
                a_rem = sa[DW-1:0];
                sb    = tqvg_pkg::div_step(b_rem, b_dq[DW-1], cols_div);
                b_dq  = {b_dq[DW-2:0], sb[DW]};
                b_rem = sb[DW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dq_a_reg[k]  <= a_dq;
                rem_a_reg[k] <= a_rem;
                dq_b_reg[k]  <= b_dq;
                rem_b_reg[k] <= b_rem;
            end
        end
    end

    // multiply stage: corner coordinates
    logic                 mul_valid_reg;
    logic [tqvg_pkg::X_W-1:0] mul_x_reg;
    logic [tqvg_pkg::Y_W-1:0] mul_y_reg;
    logic [tqvg_pkg::U_W-1:0] mul_u_reg;
    logic [tqvg_pkg::V_W-1:0] mul_v_reg;

    logic [tqvg_pkg::MAPW_W+tqvg_pkg::TW_W-1:0] prod_x;
    logic [DW+tqvg_pkg::TW_W-1:0]               prod_y;
    logic [tqvg_pkg::TEXW_W+tqvg_pkg::TW_W-1:0] prod_u;
    logic [DW+tqvg_pkg::TW_W-1:0]               prod_v;

    assign prod_x = rem_a_reg[NST-1][tqvg_pkg::MAPW_W-1:0] * tile_width_reg;
    assign prod_y = dq_a_reg[NST-1] * tile_height_reg;
    assign prod_u = rem_b_reg[NST-1][tqvg_pkg::TEXW_W-1:0] * tile_width_reg;
    assign prod_v = dq_b_reg[NST-1] * tile_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= dv_valid_reg[NST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_x_reg <= prod_x[tqvg_pkg::X_W-1:0];
            mul_y_reg <= prod_y[tqvg_pkg::Y_W-1:0];
            mul_u_reg <= prod_u[tqvg_pkg::U_W-1:0];
            mul_v_reg <= prod_v[tqvg_pkg::V_W-1:0];
        end
    end

    // output register: both corners of the quad, vertex counter
    logic [tqvg_pkg::X_W-1:0] ser_x_reg, ser_xw_reg;
    logic [tqvg_pkg::Y_W-1:0] ser_y_reg, ser_yh_reg;
    logic [tqvg_pkg::U_W-1:0] ser_u_reg, ser_uw_reg;
    logic [tqvg_pkg::V_W-1:0] ser_v_reg, ser_vh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            vtx_cnt_reg   <= '0;
        end else if (adv) begin
            ser_valid_reg <= mul_valid_reg;
            vtx_cnt_reg   <= '0;
        end else if (m_ready) begin
            vtx_cnt_reg <= vtx_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ser_x_reg  <= mul_x_reg;
            ser_xw_reg <= mul_x_reg + tqvg_pkg::X_W'(tile_width_reg);
            ser_y_reg  <= mul_y_reg;
            ser_yh_reg <= mul_y_reg + tqvg_pkg::Y_W'(tile_height_reg);
            if (cols_zero) begin
                ser_u_reg  <= '0;
                ser_uw_reg <= '0;
                ser_v_reg  <= '0;
                ser_vh_reg <= '0;
            end else begin
                ser_u_reg  <= mul_u_reg;
                ser_uw_reg <= mul_u_reg + tqvg_pkg::U_W'(tile_width_reg);
                ser_v_reg  <= mul_v_reg;
                ser_vh_reg <= mul_v_reg + tqvg_pkg::V_W'(tile_height_reg);
            end
        end
    end

    // corner select for the current vertex
    always_comb begin
        case (vtx_cnt_reg)
            tqvg_pkg::VTX_BL_A, tqvg_pkg::VTX_BL_B: begin
                m_pos_x = ser_x_reg;
                m_pos_y = ser_yh_reg;
                m_tex_u = ser_u_reg;
                m_tex_v = ser_vh_reg;
            end
            tqvg_pkg::VTX_TR_A, tqvg_pkg::VTX_TR_B: begin
                m_pos_x = ser_xw_reg;
                m_pos_y = ser_y_reg;
                m_tex_u = ser_uw_reg;
                m_tex_v = ser_v_reg;
            end
            tqvg_pkg::VTX_BR: begin
                m_pos_x = ser_xw_reg;
                m_pos_y = ser_yh_reg;
                m_tex_u = ser_uw_reg;
                m_tex_v = ser_vh_reg;
            end
            default: begin
                m_pos_x = ser_x_reg;
                m_pos_y = ser_y_reg;
                m_tex_u = ser_u_reg;
                m_tex_v = ser_v_reg;
            end
        endcase
    end

    assign m_valid         = ser_valid_reg;
    assign m_vertex_number = vtx_cnt_reg;
    assign m_last_vertex   = (vtx_cnt_reg == tqvg_pkg::VTX_TR_B);

    // vertex counter steps by one within a quad
    a_vtx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_vertex)
        |=> (m_valid && m_vertex_number == $past(m_vertex_number) + 3'd1))
        else $error("vertex counter skipped or lost its word");

    // a new quad always starts at vertex 0
    a_quad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_vertex) |=> (!m_valid || m_vertex_number == '0))
        else $error("quad did not restart at vertex 0");

    // a stalled quad holds the pipeline behind it
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_ready && m_last_vertex)) |=> ($stable(mul_valid_reg)
        && $stable(dv_valid_reg)))
        else $error("pipeline moved while the output quad was in flight");

    // no cell is taken while the column count is being recomputed
    a_cols_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (cols_busy_reg && !s_ready))
        else $error("input taken while column count is stale");

endmodule

`default_nettype wire

>>> tb/sv/tilemap_quad_vertex_generator_top_tb.sv
`default_nettype none

module tilemap_quad_vertex_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one map cell waiting to be sent
    typedef struct {
        logic [tqvg_pkg::CELL_W-1:0] cell_index;
        logic [tqvg_pkg::TILE_W-1:0] tile_number;
    } cell_word_t;

    // one vertex expected on the output
    typedef struct {
        logic [tqvg_pkg::X_W-1:0] pos_x;
        logic [tqvg_pkg::Y_W-1:0] pos_y;
        logic [tqvg_pkg::U_W-1:0] tex_u;
        logic [tqvg_pkg::V_W-1:0] tex_v;
        tqvg_pkg::vertex_t        vertex_number;
        logic                     last_vertex;
    } vertex_word_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [1:0]                    cfg_addr = tqvg_pkg::REG_MAP_WIDTH;
    logic [tqvg_pkg::TEXW_W-1:0]   cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [tqvg_pkg::CELL_W-1:0]   s_cell_index = '0;
    logic [tqvg_pkg::TILE_W-1:0]   s_tile_number = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [tqvg_pkg::X_W-1:0]      m_pos_x;
    logic [tqvg_pkg::Y_W-1:0]      m_pos_y;
    logic [tqvg_pkg::U_W-1:0]      m_tex_u;
    logic [tqvg_pkg::V_W-1:0]      m_tex_v;
    logic [tqvg_pkg::VTX_W-1:0]    m_vertex_number;
    logic                          m_last_vertex;

    // local copy of the tiling registers
    logic [tqvg_pkg::MAPW_W-1:0]   map_width_cfg = tqvg_pkg::MAP_WIDTH_RST;
    logic [tqvg_pkg::TW_W-1:0]     tile_width_cfg = tqvg_pkg::TILE_WIDTH_RST;
    logic [tqvg_pkg::TW_W-1:0]     tile_height_cfg = tqvg_pkg::TILE_HEIGHT_RST;
    logic [tqvg_pkg::TEXW_W-1:0]   texture_width_cfg = tqvg_pkg::TEXTURE_WIDTH_RST;

    cell_word_t          cell_queue[$];
    vertex_word_t        vertex_queue[$];
    vertex_word_t        vertex_head;
    cell_word_t          cell_next;
    int                  mismatches = 0;
    int                  send_idle_pct = 31;
    int                  recv_idle_pct = 70;

    tilemap_quad_vertex_generator_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_index    (s_cell_index),
        .s_tile_number   (s_tile_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_tex_u         (m_tex_u),
        .m_tex_v         (m_tex_v),
        .m_vertex_number (m_vertex_number),
        .m_last_vertex   (m_last_vertex)
    );

    always #5 aclk = ~aclk;

    // six quad vertices of one cell under the current registers
    function automatic void predict_quad(input logic [tqvg_pkg::CELL_W-1:0] cell_idx,
                                         input logic [tqvg_pkg::TILE_W-1:0] tile);
        longint unsigned   mw, w, h, x, y, u, v, uw, vh, cols;
        longint unsigned   px, py, pu, pv;
        tqvg_pkg::vertex_t vn;
        vertex_word_t      vw;
        if (tile == '0) begin
            return;
        end
        // zero map width counts as one tile per row
        mw = (map_width_cfg == '0) ? 1 : map_width_cfg;
        w = tile_width_cfg;
        h = tile_height_cfg;
        x = (cell_idx % mw) * w;
        y = (cell_idx / mw) * h;
        // no tileset columns gives zero texture coordinates
        cols = (w != 0) ? texture_width_cfg / w : 0;
        if (cols != 0) begin
            u = ((tile - 1) % cols) * w;
            v = ((tile - 1) / cols) * h;
            uw = u + w;
            vh = v + h;
        end else begin
            u = 0;
            v = 0;
            uw = 0;
            vh = 0;
        end
        for (int k = 0; k < 6; k++) begin
            vn = tqvg_pkg::vertex_t'(k);
            case (vn)
                tqvg_pkg::VTX_BL_A, tqvg_pkg::VTX_BL_B: begin
                    px = x;     py = y + h; pu = u;  pv = vh;
                end
                tqvg_pkg::VTX_TR_A, tqvg_pkg::VTX_TR_B: begin
                    px = x + w; py = y;     pu = uw; pv = v;
                end
                tqvg_pkg::VTX_TL: begin
                    px = x;     py = y;     pu = u;  pv = v;
                end
                default: begin
                    px = x + w; py = y + h; pu = uw; pv = vh;
                end
            endcase
            vw.pos_x = tqvg_pkg::X_W'(px);
            vw.pos_y = tqvg_pkg::Y_W'(py);
            vw.tex_u = tqvg_pkg::U_W'(pu);
            vw.tex_v = tqvg_pkg::V_W'(pv);
            vw.vertex_number = vn;
            vw.last_vertex = (vn == tqvg_pkg::VTX_TR_B);
            vertex_queue = {vertex_queue, vw};
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_cell(input logic [tqvg_pkg::CELL_W-1:0] cell_idx,
                                       input logic [tqvg_pkg::TILE_W-1:0] tile);
        cell_word_t cw;
        cw.cell_index = cell_idx;
        cw.tile_number = tile;
        cell_queue = {cell_queue, cw};
    endfunction

    // wait until no cell is pending and every vertex has come out
    task automatic wait_idle();
        do @(negedge aclk);
        while (cell_queue.size() != 0 || s_valid || vertex_queue.size() != 0);
    endtask

    // reprogram the tiling registers with the block idle
    task automatic program_tiling(input int mw, input int tw, input int th, input int txw);
        wait_idle();
        // empty cells may still be in the pipeline
        repeat (16) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= tqvg_pkg::REG_MAP_WIDTH;
        cfg_wdata <= tqvg_pkg::TEXW_W'(mw);
        @(posedge aclk);
        cfg_addr <= tqvg_pkg::REG_TILE_WIDTH;
        cfg_wdata <= tqvg_pkg::TEXW_W'(tw);
        @(posedge aclk);
        cfg_addr <= tqvg_pkg::REG_TILE_HEIGHT;
        cfg_wdata <= tqvg_pkg::TEXW_W'(th);
        @(posedge aclk);
        cfg_addr <= tqvg_pkg::REG_TEXTURE_WIDTH;
        cfg_wdata <= tqvg_pkg::TEXW_W'(txw);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        map_width_cfg = tqvg_pkg::MAPW_W'(mw);
        tile_width_cfg = tqvg_pkg::TW_W'(tw);
        tile_height_cfg = tqvg_pkg::TW_W'(th);
        texture_width_cfg = tqvg_pkg::TEXW_W'(txw);
        @(negedge aclk);
    endtask

    // cell driver: predicts on accept, loads the next word when the slot frees
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_quad(s_cell_index, s_tile_number);
            end
            if (!s_valid || s_ready) begin
                if (cell_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cell_next = cell_queue.pop_front();
                    s_valid <= 1'b1;
                    s_cell_index <= cell_next.cell_index;
                    s_tile_number <= cell_next.tile_number;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // vertex monitor with random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (vertex_queue.size() == 0) begin
                    $display("%0t: vertex with none expected, actual x %0d y %0d u %0d",
                             $time, m_pos_x, m_pos_y, m_tex_u);
                    $display("%0t: actual v %0d n %0d l %0d",
                             $time, m_tex_v, m_vertex_number, m_last_vertex);
                    mismatches++;
                end else begin
                    vertex_head = vertex_queue.pop_front();
                    check_field("pos_x", vertex_head.pos_x, m_pos_x);
                    check_field("pos_y", vertex_head.pos_y, m_pos_y);
                    check_field("tex_u", vertex_head.tex_u, m_tex_u);
                    check_field("tex_v", vertex_head.tex_v, m_tex_v);
                    check_field("vertex_number", vertex_head.vertex_number,
                                m_vertex_number);
                    check_field("last_vertex", vertex_head.last_vertex, m_last_vertex);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // stimulus
    initial begin
        int mw, tw, th, txw, r;
        logic [tqvg_pkg::CELL_W-1:0] cell_idx;
        logic [tqvg_pkg::TILE_W-1:0] tile;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset tiling: corners of the fields and an empty cell
        queue_cell(16'd0, 16'd1);
        queue_cell(16'hFFFF, 16'hFFFF);
        queue_cell(16'h1234, 16'd0);
        queue_cell(16'd0, 16'hFFFF);
        queue_cell(16'd5, 16'd17);

        // zero map width, tiles of 256, texture width 16384
        program_tiling(0, 256, 256, 16384);
        queue_cell(16'd0, 16'd1);
        queue_cell(16'hFFFF, 16'hFFFF);
        queue_cell(16'h8000, 16'h0040);
        queue_cell(16'd3, 16'd0);

        // zero tile width: no tileset columns
        program_tiling(1024, 0, 1, 1);
        queue_cell(16'd1023, 16'd1);
        queue_cell(16'd1024, 16'd2);
        queue_cell(16'hFFFF, 16'hFFFF);

        // texture narrower than one tile
        program_tiling(7, 256, 3, 255);
        queue_cell(16'd6, 16'd1);
        queue_cell(16'd7, 16'd9);
        queue_cell(16'hFFFF, 16'h7FFF);

        // all-ones writes, upper bits dropped by the map width and tile size registers
        program_tiling(32767, 32767, 32767, 32767);
        queue_cell(16'd0, 16'd64);
        queue_cell(16'd2046, 16'd65);
        queue_cell(16'hFFFF, 16'hFFFF);

        // one-pixel tiles, zero height, single tileset column
        program_tiling(2047, 1, 0, 1);
        queue_cell(16'd2047, 16'd1);
        queue_cell(16'hAAAA, 16'h5555);
        queue_cell(16'h5555, 16'hAAAA);

        // random tilings and cells
        for (int phase = 0; phase < 6; phase++) begin
            mw = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 64);
            tw = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 32);
            th = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 32);
            txw = ($urandom_range(3) == 0) ? $urandom_range(32767)
                                           : (tw % 512) * $urandom_range(1, 16);
            program_tiling(mw, tw, th, txw);
            send_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 70 : 0;
            recv_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 31 : 0;
            for (int n = 0; n < 33; n++) begin
                // hold the sender until the output has drained
                if (n == 16) begin
                    wait_idle();
                end
                r = $urandom_range(99);
                if (r < 60) begin
                    cell_idx = tqvg_pkg::CELL_W'($urandom_range(1023));
                end else begin
                    cell_idx = tqvg_pkg::CELL_W'($urandom_range(65535));
                end
                r = $urandom_range(99);
                if (r < 20) begin
                    tile = '0;
                end else if (r < 75) begin
                    tile = tqvg_pkg::TILE_W'($urandom_range(1, 300));
                end else begin
                    tile = tqvg_pkg::TILE_W'($urandom_range(1, 65535));
                end
                queue_cell(cell_idx, tile);
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && vertex_queue.size() == 0) begin
            $display("tilemap_quad_vertex_generator_top: match");
        end else begin
            $display("tilemap_quad_vertex_generator_top: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tilemap_quad_vertex_generator_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
